>>> hdl/siphash_2_4_keyed_hash_core_macros.svh
// Assertion macros used by the checker file of the hash core.
`ifndef SIPHASH_2_4_KEYED_HASH_CORE_MACROS_SVH
`define SIPHASH_2_4_KEYED_HASH_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SIP24_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sip24 check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SIP24_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sip24 check failed");

`endif

>>> hdl/sip24_pkg.sv
// Shared types, constants and round functions of the SipHash-2-4 core.
`timescale 1ns / 1ps

package sip24_pkg;

    localparam logic [63:0] IV_ZERO  = 64'h736f6d6570736575;
    localparam logic [63:0] IV_ONE   = 64'h646f72616e646f6d;
    localparam logic [63:0] IV_TWO   = 64'h6c7967656e657261;
    localparam logic [63:0] IV_THREE = 64'h7465646279746573;
    localparam logic [63:0] FINAL_XOR = 64'h00000000000000ff;

    localparam int WORD_BYTES   = 8;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

    // Register select: paddr bit 3 picks the key half.
    localparam logic REG_KEY_LOW  = 1'b0;
    localparam logic REG_KEY_HIGH = 1'b1;

    // Engine step codes.
    localparam logic [1:0] ST_ABSORB  = 2'd0;
    localparam logic [1:0] ST_LENGTH  = 2'd1;
    localparam logic [1:0] ST_FINAL_A = 2'd2;
    localparam logic [1:0] ST_FINAL_B = 2'd3;

    typedef struct packed {
        logic [63:0] v0;
        logic [63:0] v1;
        logic [63:0] v2;
        logic [63:0] v3;
    } lanes_t;

    typedef struct packed {
        logic [63:0] word;
        logic [3:0]  nbytes;
        logic        full;
        logic        last;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_head_t;

    function automatic lanes_t sip_round(input lanes_t l);
        lanes_t r;
        r = l;
        r.v0 = r.v0 + r.v1;
        r.v1 = {r.v1[50:0], r.v1[63:51]} ^ r.v0;
        r.v0 = {r.v0[31:0], r.v0[63:32]};
        r.v2 = r.v2 + r.v3;
        r.v3 = {r.v3[47:0], r.v3[63:48]} ^ r.v2;
        r.v0 = r.v0 + r.v3;
        r.v3 = {r.v3[42:0], r.v3[63:43]} ^ r.v0;
        r.v2 = r.v2 + r.v1;
        r.v1 = {r.v1[46:0], r.v1[63:47]} ^ r.v2;
        r.v2 = {r.v2[31:0], r.v2[63:32]};
        return r;
    endfunction

    function automatic lanes_t sip_double(input lanes_t l);
        return sip_round(sip_round(l));
    endfunction

    function automatic lanes_t sip_compress(input lanes_t l, input logic [63:0] m);
        lanes_t r;
        r = l;
        r.v3 = r.v3 ^ m;
        r = sip_double(r);
        r.v0 = r.v0 ^ m;
        return r;
    endfunction

    function automatic lanes_t sip_init(input logic [63:0] k0, input logic [63:0] k1);
        lanes_t r;
        r.v0 = k0 ^ IV_ZERO;
        r.v1 = k1 ^ IV_ONE;
        r.v2 = k0 ^ IV_TWO;
        r.v3 = k1 ^ IV_THREE;
        return r;
    endfunction

endpackage

>>> hdl/sip24_front.sv
// Input side: classify incoming words and queue them for the round engine.
`timescale 1ns / 1ps

module sip24_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [63:0]          in_word,
    input  logic [3:0]           in_bytes,
    input  logic                 in_last,
    output sip24_pkg::queue_head_t head,
    input  logic                 pop
);

    sip24_pkg::item_t                  entry_reg [sip24_pkg::QUEUE_DEPTH];
    logic [sip24_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [sip24_pkg::QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [sip24_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [sip24_pkg::QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [sip24_pkg::QUEUE_CNT_W-1:0] count_reg;
    logic [sip24_pkg::QUEUE_CNT_W-1:0] count_next;
    sip24_pkg::item_t                  cls;
    logic [3:0]                        n_sat;
    logic                              push;
    logic                              do_pop;

    // Saturate the count, mark full words and drop bytes above the tail.
    always_comb
    begin
        n_sat = (in_bytes > 4'd8) ? 4'd8 : in_bytes;
        cls.last = in_last;
        cls.full = !in_last || (n_sat == 4'd8);
        cls.nbytes = cls.full ? 4'd8 : n_sat;
        for (int i = 0; i < sip24_pkg::WORD_BYTES; i++)
        begin
            cls.word[8*i +: 8] = (cls.full || (4'(i) < n_sat)) ? in_word[8*i +: 8] : 8'h00;
        end
    end

    assign in_ready   = (count_reg != sip24_pkg::QUEUE_CNT_W'(sip24_pkg::QUEUE_DEPTH));
    assign push       = in_valid && in_ready;
    assign do_pop     = pop && head.valid;
    assign head.valid = (count_reg != '0);
    assign head.item  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + sip24_pkg::QUEUE_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + sip24_pkg::QUEUE_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + sip24_pkg::QUEUE_CNT_W'(push)
                      - sip24_pkg::QUEUE_CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

>>> hdl/sip24_back.sv
// Round engine: absorb queued words, finalize, and hold the hash for output.
`timescale 1ns / 1ps

module sip24_back
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  sip24_pkg::queue_head_t head,
    output logic                   pop,
    input  logic [63:0]            key_low,
    input  logic [63:0]            key_high,
    input  logic                   reload,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [63:0]            out_hash
);

    sip24_pkg::lanes_t lanes_reg;
    sip24_pkg::lanes_t lanes_next;
    sip24_pkg::lanes_t fin;
    logic [7:0]        len_reg;
    logic [7:0]        len_next;
    logic [7:0]        len_sum;
    logic [1:0]        step_reg;
    logic [1:0]        step_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [63:0]       out_hash_reg;
    logic [63:0]       out_hash_next;
    logic              out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_hash  = out_hash_reg;

    always_comb
    begin
        lanes_next     = lanes_reg;
        len_next       = len_reg;
        step_next      = step_reg;
        pop            = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        out_hash_next  = out_hash_reg;
        len_sum        = len_reg + {4'h0, head.item.nbytes};
        fin            = sip24_pkg::sip_double(lanes_reg);

        if (reload)
        begin
            lanes_next = sip24_pkg::sip_init(key_low, key_high);
            len_next   = '0;
            step_next  = sip24_pkg::ST_ABSORB;
        end
        else if (head.valid)
        begin
            unique case (step_reg)
                sip24_pkg::ST_ABSORB:
                begin
                    len_next = len_sum;
                    if (head.item.full)
                    begin
                        lanes_next = sip24_pkg::sip_compress(lanes_reg, head.item.word);
                        if (head.item.last)
                        begin
                            step_next = sip24_pkg::ST_LENGTH;
                        end
                        else
                        begin
                            pop = 1'b1;
                        end
                    end
                    else
                    begin
                        lanes_next = sip24_pkg::sip_compress(lanes_reg,
                                         {len_sum, 56'h0} | head.item.word);
                        step_next  = sip24_pkg::ST_FINAL_A;
                    end
                end
                sip24_pkg::ST_LENGTH:
                begin
                    lanes_next = sip24_pkg::sip_compress(lanes_reg, {len_reg, 56'h0});
                    step_next  = sip24_pkg::ST_FINAL_A;
                end
                sip24_pkg::ST_FINAL_A:
                begin
                    lanes_next    = lanes_reg;
                    lanes_next.v2 = lanes_reg.v2 ^ sip24_pkg::FINAL_XOR;
                    lanes_next    = sip24_pkg::sip_double(lanes_next);
                    step_next     = sip24_pkg::ST_FINAL_B;
                end
                sip24_pkg::ST_FINAL_B:
                begin
                    // Hold here until the output register can take the hash.
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_hash_next  = fin.v0 ^ fin.v1 ^ fin.v2 ^ fin.v3;
                        lanes_next     = sip24_pkg::sip_init(key_low, key_high);
                        len_next       = '0;
                        step_next      = sip24_pkg::ST_ABSORB;
                        pop            = 1'b1;
                    end
                end
                default:
                begin
                    step_next = sip24_pkg::ST_ABSORB;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lanes_reg     <= sip24_pkg::sip_init(64'h0, 64'h0);
            len_reg       <= '0;
            step_reg      <= sip24_pkg::ST_ABSORB;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            lanes_reg     <= lanes_next;
            len_reg       <= len_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_hash_reg <= out_hash_next;
    end

endmodule

>>> hdl/siphash_2_4_keyed_hash_core.sv
// A hash reaches m_axis via the steps absorb, length (full last word only), final A and final B.
// Throughput: one non-last word per cycle while absorbing (two rounds per cycle in the engine);
// the last word holds the engine in its closing steps while the input queue accepts until full.
// Reset clears the queue and output, zeroes the key and loads the lanes from it.
// A key write reloads the lanes in the cycle after it and drops what a partial message absorbed.
// Top level of the SipHash-2-4 keyed hash core.
`timescale 1ns / 1ps

module siphash_2_4_keyed_hash_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // message_word[63:0], bytes_in_word[67:64], zero[71:68]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // hash_value[63:0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    logic [63:0]            key_low_reg;
    logic [63:0]            key_low_next;
    logic [63:0]            key_high_reg;
    logic [63:0]            key_high_next;
    logic                   reload_reg;
    logic                   reload_next;
    logic                   cfg_write;
    sip24_pkg::queue_head_t head;
    logic                   pop;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        key_low_next  = key_low_reg;
        key_high_next = key_high_reg;
        reload_next   = cfg_write;
        if (cfg_write)
        begin
            unique case (paddr[3])
                sip24_pkg::REG_KEY_LOW:  key_low_next  = pwdata;
                sip24_pkg::REG_KEY_HIGH: key_high_next = pwdata;
                default:                 key_low_next  = key_low_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3])
            sip24_pkg::REG_KEY_LOW:  prdata = key_low_reg;
            sip24_pkg::REG_KEY_HIGH: prdata = key_high_reg;
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
            reload_reg   <= 1'b0;
        end
        else
        begin
            key_low_reg  <= key_low_next;
            key_high_reg <= key_high_next;
            reload_reg   <= reload_next;
        end
    end

    sip24_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_word  (s_axis_tdata[63:0]),
        .in_bytes (s_axis_tdata[67:64]),
        .in_last  (s_axis_tlast),
        .head     (head),
        .pop      (pop)
    );

    sip24_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .key_low   (key_low_reg),
        .key_high  (key_high_reg),
        .reload    (reload_reg),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_hash  (m_axis_tdata)
    );

endmodule

>>> hdl/sip24_checker.sv
// Port-level checks for the hash core, bound to the top level.
`timescale 1ns / 1ps
`include "siphash_2_4_keyed_hash_core_macros.svh"

module sip24_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [71:0] s_axis_tdata,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [3:0]  paddr,
    input logic [63:0] pwdata,
    input logic [63:0] prdata,
    input logic        pready
);

    `SIP24_ASSERT_NOW(a_pready_high, 1'b1, pready)
    `SIP24_ASSERT_NEXT(a_key_low_readback, psel && penable && pwrite && !paddr[3], paddr[3] || prdata == $past(pwdata))
    `SIP24_ASSERT_NEXT(a_key_high_readback, psel && penable && pwrite && paddr[3], !paddr[3] || prdata == $past(pwdata))
    `SIP24_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind siphash_2_4_keyed_hash_core sip24_checker u_sip24_checker (.*);
